### hw/rtl/gat_pkg.sv
// ============================================================================
// gat_pkg - shared constants for the graph adjacency tracker
// Field widths of the request and response words, the request codes and the default matrix size.
// ============================================================================
package gat_pkg;

    // request codes
    localparam logic REQ_WRITE = 1'b0;

    // default matrix size
    localparam int DEF_VERTICES = 16;

    // fixed payload field widths
    localparam int ROW_W  = 4;
    localparam int EDGE_W = 9;
    localparam int DEG_W  = 5;
    localparam int MASK_W = 16;

endpackage

### hw/rtl/gat_if.sv
// ============================================================================
// gat_if - request and response channels of the graph adjacency tracker
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ============================================================================
interface gat_req_if import gat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             bit_req;

    modport source (output valid, req_type, row, col, bit_req, input ready);
    modport sink   (input valid, req_type, row, col, bit_req, output ready);
endinterface

interface gat_rsp_if import gat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              symmetric;
    logic [EDGE_W-1:0] edge_count;
    logic [DEG_W-1:0]  out_degree;
    logic [DEG_W-1:0]  in_degree;
    logic [MASK_W-1:0] row_edges;

    modport source (output valid, symmetric, edge_count, out_degree, in_degree, row_edges,
                    input ready);
    modport sink   (input valid, symmetric, edge_count, out_degree, in_degree, row_edges,
                    output ready);
endinterface

### hw/rtl/graph_adjacency_tracker.sv
// ============================================================================
// graph_adjacency_tracker - adjacency matrix with degree and symmetry tracking
// Stores the matrix row-wise and column-wise and keeps running counts.
// ============================================================================
// The block takes one request word per clock unless a held response stalls it,
// and returns one response word for each through the request stage and the
// response register. The matrix lives in two synchronous memories: the row store
// holds each row's bits with its out-degree, the column store holds each column's
// bits with its in-degree. A request reads the row store at the vertex and the
// column store at the vertex and at the destination; the request stage then
// modifies and writes back, and a bypass register covers a read that meets a
// write of the previous request. Per-entry valid bits make both stores read as
// zero right after reset, so the block is ready at once with no clearing pass.
// A write returns the same response as a query of its row vertex made after it.
module graph_adjacency_tracker import gat_pkg::*; #(
    parameter int VERTICES = DEF_VERTICES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gat_req_if.sink   i_req,
    gat_rsp_if.source o_rsp
);

    localparam int AW  = $clog2(VERTICES);
    localparam int NW  = $clog2(VERTICES + 1);
    localparam int WW  = NW + VERTICES;
    localparam int TW  = $clog2(VERTICES * VERTICES + 1);
    localparam int PW  = $clog2(VERTICES * (VERTICES - 1) / 2 + 1);

    // memories: {count, bits}
    logic [WW-1:0] mem_a [VERTICES];
    logic [WW-1:0] mem_b [VERTICES];
    logic          r_a_vld [VERTICES];
    logic          r_b_vld [VERTICES];

    logic          r_s1_vld;
    logic          r_req;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_col;
    logic          r_bit;

    logic [WW-1:0] r_qa, r_qbr, r_qbc;
    logic          r_qa_v, r_qbr_v, r_qbc_v;
    logic          r_fa, r_fbr, r_fbc;
    logic [WW-1:0] r_fwd_a, r_fwd_b;

    logic [PW-1:0] r_asym, n_asym;
    logic [TW-1:0] r_tot, n_tot;
    logic [NW-1:0] r_diag, n_diag;

    logic              r_ov;
    logic              r_o_sym;
    logic [EDGE_W-1:0] r_o_edges;
    logic [DEG_W-1:0]  r_o_outd;
    logic [DEG_W-1:0]  r_o_ind;
    logic [MASK_W-1:0] r_o_mask;

    logic          accept;
    logic          s1_adv;
    logic [AW-1:0] rd_addr_r, rd_addr_c;
    logic [AW-1:0] wa_addr, wb_addr;
    logic          mem_wr;

    logic [WW-1:0] eff_a, eff_br, eff_bc;
    logic [WW-1:0] mod_a, mod_bc, new_a, new_bc;
    logic [NW-1:0] cnt_a, cnt_bc, in_cnt;
    logic [VERTICES-1:0] bits_a, bits_bc, tri_mask, shown;
    logic          row_ok, col_ok, old_bit, mirror, do_wr, sym;
    logic [TW-1:0] off_diag;

    assign s1_adv      = r_s1_vld && (!r_ov || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    assign rd_addr_r = AW'(i_req.row);
    assign rd_addr_c = AW'(i_req.col);
    assign wa_addr   = AW'(r_row);
    assign wb_addr   = AW'(r_col);

    // ---------------- read / modify ----------------
    always_comb begin
        eff_a  = r_fa  ? r_fwd_a : (r_qa_v  ? r_qa  : '0);
        eff_br = r_fbr ? r_fwd_b : (r_qbr_v ? r_qbr : '0);
        eff_bc = r_fbc ? r_fwd_b : (r_qbc_v ? r_qbc : '0);

        row_ok  = 32'(r_row) < VERTICES;
        col_ok  = 32'(r_col) < VERTICES;
        bits_a  = eff_a[VERTICES-1:0];
        bits_bc = eff_bc[VERTICES-1:0];
        cnt_a   = eff_a[WW-1:VERTICES];
        cnt_bc  = eff_bc[WW-1:VERTICES];
        old_bit = bits_a[wb_addr];
        // column store at the row vertex holds entry (col,row)
        mirror  = eff_br[wb_addr];
        do_wr   = (r_req == REQ_WRITE) && row_ok && col_ok && (old_bit != r_bit);

        bits_a[wb_addr]  = r_bit;
        bits_bc[wa_addr] = r_bit;
        if (r_bit) begin
            mod_a  = {cnt_a + NW'(1), bits_a};
            mod_bc = {cnt_bc + NW'(1), bits_bc};
        end else begin
            mod_a  = {cnt_a - NW'(1), bits_a};
            mod_bc = {cnt_bc - NW'(1), bits_bc};
        end
        new_a  = do_wr ? mod_a  : eff_a;
        new_bc = do_wr ? mod_bc : eff_bc;
        mem_wr = s1_adv && do_wr;

        n_asym = r_asym;
        n_tot  = r_tot;
        n_diag = r_diag;
        if (do_wr) begin
            if (r_row != r_col) begin
                n_asym = (old_bit == mirror) ? r_asym + PW'(1) : r_asym - PW'(1);
            end
            n_tot = r_bit ? r_tot + TW'(1) : r_tot - TW'(1);
            if (r_row == r_col) begin
                n_diag = r_bit ? r_diag + NW'(1) : r_diag - NW'(1);
            end
        end

        sym      = (n_asym == '0);
        off_diag = n_tot - TW'(n_diag);
        in_cnt   = (r_row == r_col) ? new_bc[WW-1:VERTICES] : eff_br[WW-1:VERTICES];
        for (int j = 0; j < VERTICES; j++) begin
            tri_mask[j] = !sym || (j < int'(r_row));
        end
        shown = new_a[VERTICES-1:0] & tri_mask;
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_a[wa_addr] <= new_a;
            mem_b[wb_addr] <= new_bc;
        end
        if (accept) begin
            r_qa  <= mem_a[rd_addr_r];
            r_qbr <= mem_b[rd_addr_r];
            r_qbc <= mem_b[rd_addr_c];
            // bypass a write landing at the same edge
            r_fa    <= mem_wr && (wa_addr == rd_addr_r);
            r_fbr   <= mem_wr && (wb_addr == rd_addr_r);
            r_fbc   <= mem_wr && (wb_addr == rd_addr_c);
            r_fwd_a <= new_a;
            r_fwd_b <= new_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VERTICES; k++) begin
                r_a_vld[k] <= 1'b0;
                r_b_vld[k] <= 1'b0;
            end
            r_qa_v  <= 1'b0;
            r_qbr_v <= 1'b0;
            r_qbc_v <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_a_vld[wa_addr] <= 1'b1;
                r_b_vld[wb_addr] <= 1'b1;
            end
            if (accept) begin
                r_qa_v  <= r_a_vld[rd_addr_r];
                r_qbr_v <= r_b_vld[rd_addr_r];
                r_qbc_v <= r_b_vld[rd_addr_c];
            end
        end
    end

    // ---------------- request stage and counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_asym   <= '0;
            r_tot    <= '0;
            r_diag   <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_asym <= n_asym;
                r_tot  <= n_tot;
                r_diag <= n_diag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.req_type;
            r_row <= i_req.row;
            r_col <= i_req.col;
            r_bit <= i_req.bit_req;
        end
    end

    // ---------------- response register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_adv) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_sym   <= sym;
            r_o_edges <= sym ? EDGE_W'(off_diag >> 1) : EDGE_W'(n_tot);
            r_o_outd  <= row_ok ? DEG_W'(new_a[WW-1:VERTICES]) : '0;
            r_o_ind   <= row_ok ? DEG_W'(in_cnt) : '0;
            r_o_mask  <= row_ok ? MASK_W'(shown) : '0;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.symmetric  = r_o_sym;
    assign o_rsp.edge_count = r_o_edges;
    assign o_rsp.out_degree = r_o_outd;
    assign o_rsp.in_degree  = r_o_ind;
    assign o_rsp.row_edges  = r_o_mask;

endmodule
